FILE: sv/sfp_pkg.sv
// Shared types, message kind codes and the field selection function for the
// status frame field parser. Every other file of the block depends on this one.
`default_nettype none

package sfp_pkg;

	localparam int unsigned StoreDepth = 18;
	localparam int unsigned CountW = 5;

	localparam logic [7:0] TYPE_INFO = 8'ha2;
	localparam logic [7:0] TYPE_PARAMS = 8'ha6;
	localparam logic [7:0] TYPE_RECORD = 8'ha7;

	localparam logic [CountW-1:0] MIN_INFO = 5'd15;
	localparam logic [CountW-1:0] MIN_PARAMS = 5'd14;
	localparam logic [CountW-1:0] MIN_RECORD = 5'd18;
	localparam logic [CountW-1:0] MIN_FRAME = 5'd2;
	localparam logic [CountW-1:0] COUNT_MAX = 5'd31;

	localparam logic [1:0] KIND_NONE = 2'd0;
	localparam logic [1:0] KIND_INFO = 2'd1;
	localparam logic [1:0] KIND_PARAMS = 2'd2;
	localparam logic [1:0] KIND_RECORD = 2'd3;

	localparam logic [3:0] LAST_IDX_NONE = 4'd0;
	localparam logic [3:0] LAST_IDX_INFO = 4'd5;
	localparam logic [3:0] LAST_IDX_PARAMS = 4'd9;
	localparam logic [3:0] LAST_IDX_RECORD = 4'd5;

	typedef logic [StoreDepth-1:0][7:0] bytes_t;

	typedef struct packed {
		logic [1:0] kind;
		bytes_t     data;
	} frame_t;

	function automatic logic [3:0] last_index(input logic [1:0] kind);
		logic [3:0] r;
		case (kind)
			KIND_INFO: r = LAST_IDX_INFO;
			KIND_PARAMS: r = LAST_IDX_PARAMS;
			KIND_RECORD: r = LAST_IDX_RECORD;
			default: r = LAST_IDX_NONE;
		endcase
		return r;
	endfunction

	function automatic logic [23:0] wide3(input bytes_t d, input logic [4:0] o);
		return {d[o], d[o + 5'd1], d[o + 5'd2]};
	endfunction

	function automatic logic [23:0] field_value(input logic [1:0] kind,
			input logic [3:0] idx, input bytes_t d);
		logic [23:0] r;
		r = 24'd0;
		case (kind)
			KIND_INFO: begin
				case (idx)
					4'd0: r = {16'd0, d[2]};
					4'd1: r = {16'd0, d[3]};
					4'd2: r = {16'd0, d[4]};
					4'd3: r = wide3(d, 5'd5);
					4'd4: r = wide3(d, 5'd8);
					4'd5: r = wide3(d, 5'd11);
					default: r = 24'd0;
				endcase
			end
			KIND_PARAMS: begin
				case (idx)
					4'd0: r = {16'd0, d[2]};
					4'd1: r = wide3(d, 5'd3);
					4'd2: r = {16'd0, d[6]};
					4'd3: r = {16'd0, d[7]};
					4'd4: r = {16'd0, d[8]};
					4'd5: r = {16'd0, d[9]};
					4'd6: r = {16'd0, d[10]};
					4'd7: r = {16'd0, d[11]};
					4'd8: r = {16'd0, d[12]};
					4'd9: r = {16'd0, d[13]};
					default: r = 24'd0;
				endcase
			end
			KIND_RECORD: begin
				case (idx)
					4'd0: r = wide3(d, 5'd2);
					4'd1: r = wide3(d, 5'd5);
					4'd2: r = wide3(d, 5'd8);
					4'd3: r = wide3(d, 5'd11);
					4'd4: r = wide3(d, 5'd14);
					4'd5: r = {16'd0, d[17]};
					default: r = 24'd0;
				endcase
			end
			default: r = 24'd0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: sv/sfp_capture.sv
// Frame capture: byte store, saturating byte count and frame type decode.
// Depends on sfp_pkg.
`default_nettype none

module sfp_capture (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           accept,
	input  wire logic [7:0]     rx_byte,
	input  wire logic           frame_end,
	output sfp_pkg::frame_t     frame
);

	logic [sfp_pkg::CountW-1:0] count_q;
	sfp_pkg::bytes_t            store_q;
	sfp_pkg::bytes_t            merged;
	logic [sfp_pkg::CountW-1:0] count_next;

	always_comb begin
		merged = store_q;
		for (int i = 0; i < sfp_pkg::StoreDepth; i++) begin
			if (count_q == sfp_pkg::CountW'(i)) begin
				merged[i] = rx_byte;
			end
		end
	end

	assign count_next = (count_q == sfp_pkg::COUNT_MAX) ? count_q
		: count_q + sfp_pkg::CountW'(1);

	always_comb begin
		frame.data = merged;
		frame.kind = sfp_pkg::KIND_NONE;
		if (count_next >= sfp_pkg::MIN_FRAME) begin
			if (merged[1] == sfp_pkg::TYPE_INFO && count_next >= sfp_pkg::MIN_INFO) begin
				frame.kind = sfp_pkg::KIND_INFO;
			end else if (merged[1] == sfp_pkg::TYPE_PARAMS
					&& count_next >= sfp_pkg::MIN_PARAMS) begin
				frame.kind = sfp_pkg::KIND_PARAMS;
			end else if (merged[1] == sfp_pkg::TYPE_RECORD
					&& count_next >= sfp_pkg::MIN_RECORD) begin
				frame.kind = sfp_pkg::KIND_RECORD;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			store_q <= merged;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			count_q <= frame_end ? '0 : count_next;
		end
	end

endmodule

`default_nettype wire

FILE: sv/sfp_emit.sv
// Field sequencer: holds a copy of the finished frame and hands out one field
// word per cycle unless stalled, via the result register. Depends on sfp_pkg.
`default_nettype none

module sfp_emit (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	input  wire sfp_pkg::frame_t frame,
	output logic                 busy,
	output logic                 out_valid,
	input  wire logic            out_stall,
	output logic [1:0]           message_kind,
	output logic [3:0]           field_index,
	output logic [23:0]          field_value,
	output logic                 last_field
);

	logic            active_q;
	logic            out_valid_q;
	logic [1:0]      kind_q;
	logic [3:0]      idx_q;
	sfp_pkg::bytes_t data_q;
	logic            load_out;
	logic            is_last;

	assign load_out = active_q && (!out_valid_q || !out_stall);
	assign is_last = (idx_q == sfp_pkg::last_index(kind_q));
	assign busy = active_q;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (start) begin
				active_q <= 1'b1;
			end else if (load_out && is_last) begin
				active_q <= 1'b0;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			kind_q <= frame.kind;
			data_q <= frame.data;
			idx_q <= 4'd0;
		end else if (load_out) begin
			idx_q <= idx_q + 4'd1;
		end
		if (load_out) begin
			message_kind <= kind_q;
			field_index <= idx_q;
			field_value <= sfp_pkg::field_value(kind_q, idx_q, data_q);
			last_field <= is_last;
		end
	end

`ifndef SYNTHESIS
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !active_q)
		else $error("frame started while fields still pending");
	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && last_field) |-> field_index == sfp_pkg::last_index(message_kind))
		else $error("last field flag on wrong index");
	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> field_index <= sfp_pkg::last_index(message_kind))
		else $error("field index beyond kind");
	a_start_active: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> active_q)
		else $error("sequencer did not start");
`endif

endmodule

`default_nettype wire

FILE: sv/status_frame_field_parser_top.sv
// Top level of the status frame field parser: byte capture feeding the field
// sequencer. Depends on sfp_pkg, sfp_capture and sfp_emit.
//
//   Channel | Handshake           | Word
//   input   | in_valid / in_stall | rx_byte, frame_end
//   output  | out_valid/out_stall | message_kind, field_index, field_value, last_field
//
// A byte is taken every cycle unless stalled; frame bytes are stored with no delay.
// The last byte of a frame starts a burst of 1, 6 or 10 field words, one per cycle.
// The last byte loads the sequencer, which then registers the first field word.
// A last byte that arrives while a burst is still in progress is stalled until it ends.
// Output stalls hold the result register and pause the burst.
// Reset clears the byte count and the sequencer; stored bytes are not cleared.
`default_nettype none

module status_frame_field_parser_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  rx_byte,
	input  wire logic        frame_end,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       message_kind,
	output logic [3:0]       field_index,
	output logic [23:0]      field_value,
	output logic             last_field
);

	logic            accept;
	logic            busy;
	sfp_pkg::frame_t frame;

	assign in_stall = busy && frame_end;
	assign accept = in_valid && !in_stall;

	sfp_capture u_capture (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.rx_byte   (rx_byte),
		.frame_end (frame_end),
		.frame     (frame)
	);

	sfp_emit u_emit (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (accept && frame_end),
		.frame        (frame),
		.busy         (busy),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.message_kind (message_kind),
		.field_index  (field_index),
		.field_value  (field_value),
		.last_field   (last_field)
	);

endmodule

`default_nettype wire

FILE: sim/tb_status_frame_field_parser_top.sv
// Self-checking testbench for status_frame_field_parser_top: random and directed frames
// are compared word by word against an in-bench frame parser model.
// Depends on sfp_pkg and the RTL of the block.
module tb_status_frame_field_parser_top;

	localparam int IDLE_LIMIT = 3000;
	localparam int HOLD_CYCLES = 150;
	localparam int RANDOM_BYTES = 160;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} rx_word_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [3:0]  index;
		logic [23:0] value;
		logic        last;
	} field_word_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  rx_byte = 8'd0;
	logic        frame_end = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  message_kind;
	logic [3:0]  field_index;
	logic [23:0] field_value;
	logic        last_field;

	rx_word_t    pending_bytes[$];
	field_word_t expected_fields[$];
	rx_word_t    next_word;

	logic [7:0]  frame_bytes[sfp_pkg::StoreDepth];
	logic [4:0]  byte_cnt = 5'd0;

	logic        byte_taken = 1'b0;
	int          bytes_taken = 0;
	int          errors = 0;
	int          idle_cycles = 0;
	int          burst_left = 0;
	int          gap_left = 0;
	int          hold_left = 0;
	bit          hold_done = 1'b0;
	int          seg_left = 0;
	int          seg_mode = 0;

	status_frame_field_parser_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.rx_byte(rx_byte),
		.frame_end(frame_end),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.message_kind(message_kind),
		.field_index(field_index),
		.field_value(field_value),
		.last_field(last_field)
	);

	always #1 clk = ~clk;

	function automatic logic [23:0] field_from_store(input logic [1:0] kind, input int k);
		int ofs;
		bit wide;
		case (kind)
			sfp_pkg::KIND_INFO: begin
				ofs = (k < 3) ? 2 + k : 5 + 3 * (k - 3);
				wide = (k >= 3);
			end
			sfp_pkg::KIND_PARAMS: begin
				ofs = (k == 0) ? 2 : (k == 1) ? 3 : k + 4;
				wide = (k == 1);
			end
			sfp_pkg::KIND_RECORD: begin
				ofs = (k < 5) ? 2 + 3 * k : 17;
				wide = (k < 5);
			end
			default: begin
				ofs = 0;
				wide = 1'b0;
			end
		endcase
		if (kind == sfp_pkg::KIND_NONE)
			return 24'd0;
		else if (wide)
			return {frame_bytes[ofs], frame_bytes[ofs + 1], frame_bytes[ofs + 2]};
		else
			return {16'd0, frame_bytes[ofs]};
	endfunction

	task automatic parse_frame_byte(input logic [7:0] b, input logic last);
		logic [4:0]  n;
		logic [1:0]  kind;
		int          nfields;
		field_word_t w;
		if (byte_cnt < sfp_pkg::StoreDepth)
			frame_bytes[byte_cnt] = b;
		if (byte_cnt != sfp_pkg::COUNT_MAX)
			byte_cnt = byte_cnt + 5'd1;
		if (last) begin
			n = byte_cnt;
			byte_cnt = 5'd0;
			kind = sfp_pkg::KIND_NONE;
			nfields = 1;
			if (n >= sfp_pkg::MIN_FRAME) begin
				if (frame_bytes[1] == sfp_pkg::TYPE_INFO && n >= sfp_pkg::MIN_INFO) begin
					kind = sfp_pkg::KIND_INFO;
					nfields = 6;
				end else if (frame_bytes[1] == sfp_pkg::TYPE_PARAMS
						&& n >= sfp_pkg::MIN_PARAMS) begin
					kind = sfp_pkg::KIND_PARAMS;
					nfields = 10;
				end else if (frame_bytes[1] == sfp_pkg::TYPE_RECORD
						&& n >= sfp_pkg::MIN_RECORD) begin
					kind = sfp_pkg::KIND_RECORD;
					nfields = 6;
				end
			end
			for (int k = 0; k < nfields; k++) begin
				w.kind = kind;
				w.index = k[3:0];
				w.value = field_from_store(kind, k);
				w.last = (k == nfields - 1);
				expected_fields.push_back(w);
			end
		end
	endtask

	task automatic report_mismatch(input string what, input logic [23:0] got,
			input logic [23:0] want);
		errors++;
		$display("mismatch on %s: got %0h, expected %0h at %0t", what, got, want, $time);
	endtask

	// Fill: 0 random content, 1 all ones, 2 all zeros. Byte 1 carries the frame type.
	task automatic queue_frame(input logic [7:0] type_byte, input int len, input int fill);
		rx_word_t w;
		for (int i = 0; i < len; i++) begin
			case (fill)
				1: w.data = 8'hff;
				2: w.data = 8'h00;
				default: w.data = 8'($urandom);
			endcase
			if (i == 1)
				w.data = type_byte;
			w.last = (i == len - 1);
			pending_bytes.push_back(w);
		end
	endtask

	function automatic int min_length(input logic [7:0] type_byte);
		if (type_byte == sfp_pkg::TYPE_INFO)
			return int'(sfp_pkg::MIN_INFO);
		else if (type_byte == sfp_pkg::TYPE_PARAMS)
			return int'(sfp_pkg::MIN_PARAMS);
		else
			return int'(sfp_pkg::MIN_RECORD);
	endfunction

	initial begin
		int          sel;
		int          len;
		int          fill;
		int          directed;
		logic [7:0]  type_byte;
		queue_frame(sfp_pkg::TYPE_INFO, 1, 2);
		queue_frame(8'h00, 2, 1);
		queue_frame(sfp_pkg::TYPE_INFO, 15, 1);
		queue_frame(sfp_pkg::TYPE_PARAMS, 14, 2);
		directed = pending_bytes.size();
		while (pending_bytes.size() < directed + RANDOM_BYTES) begin
			sel = $urandom_range(0, 99);
			case ($urandom_range(0, 2))
				0: type_byte = sfp_pkg::TYPE_INFO;
				1: type_byte = sfp_pkg::TYPE_PARAMS;
				default: type_byte = sfp_pkg::TYPE_RECORD;
			endcase
			fill = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : 0;
			if (sel < 68) begin
				len = min_length(type_byte) + $urandom_range(0, 3);
			end else if (sel < 78) begin
				len = min_length(type_byte) - 1 - $urandom_range(0, 1);
			end else if (sel < 85) begin
				len = $urandom_range(29, 40);
			end else if (sel < 95) begin
				type_byte = 8'($urandom);
				len = $urandom_range(1, 20);
			end else begin
				len = $urandom_range(1, 2);
			end
			queue_frame(type_byte, len, fill);
		end
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		while (pending_bytes.size() != 0 || in_valid || expected_fields.size() != 0)
			@(negedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("[status_frame_field_parser_top] OK");
		else
			$display("[status_frame_field_parser_top] ERROR");
		$finish;
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (in_valid && !byte_taken) begin
			end else if (gap_left > 0) begin
				in_valid <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (pending_bytes.size() != 0) begin
				next_word = pending_bytes.pop_front();
				rx_byte <= next_word.data;
				frame_end <= next_word.last;
				in_valid <= 1'b1;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 30);
					gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left <= hold_left - 1;
			end else if (!hold_done && bytes_taken >= 100) begin
				out_stall <= 1'b1;
				hold_left <= HOLD_CYCLES;
				hold_done <= 1'b1;
			end else begin
				if (seg_left == 0) begin
					seg_mode <= $urandom_range(0, 2);
					seg_left <= $urandom_range(4, 40);
				end else begin
					seg_left <= seg_left - 1;
				end
				case (seg_mode)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 3) == 0);
					default: out_stall <= ($urandom_range(0, 1) == 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		field_word_t want;
		if (arst_n) begin
			byte_taken <= in_valid && !in_stall;
			if (in_valid && !in_stall) begin
				parse_frame_byte(rx_byte, frame_end);
				bytes_taken <= bytes_taken + 1;
			end
			if (out_valid && !out_stall) begin
				if (expected_fields.size() == 0) begin
					report_mismatch("unexpected word", field_value, 24'd0);
				end else begin
					want = expected_fields.pop_front();
					if (message_kind !== want.kind)
						report_mismatch("message_kind", 24'(message_kind), 24'(want.kind));
					if (field_index !== want.index)
						report_mismatch("field_index", 24'(field_index), 24'(want.index));
					if (field_value !== want.value)
						report_mismatch("field_value", field_value, want.value);
					if (last_field !== want.last)
						report_mismatch("last_field", 24'(last_field), 24'(want.last));
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= IDLE_LIMIT) begin
				$display("[status_frame_field_parser_top] ERROR");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

endmodule
